>>> src/route_table_slot_manager_unit_assert.svh
// ----------------------------------------------------------------------------
// Route table slot manager assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ROUTE_TABLE_SLOT_MANAGER_UNIT_ASSERT_SVH
`define ROUTE_TABLE_SLOT_MANAGER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RTSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RTSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rtsm_pkg.sv
// ----------------------------------------------------------------------------
// rtsm_pkg
// Types, field widths and codes of the route table slot manager.
// ----------------------------------------------------------------------------
package rtsm_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 6;
    localparam int DEST_W   = 24;
    localparam int MASK_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 7;
    localparam int TL_W     = 7;

    // Input tdata layout, lowest bit up
    localparam int IN_CMD_LSB   = 0;
    localparam int IN_SLOT_LSB  = IN_CMD_LSB + CMD_W;
    localparam int IN_DEST_LSB  = IN_SLOT_LSB + SLOT_W;
    localparam int IN_MLOW_LSB  = IN_DEST_LSB + DEST_W;
    localparam int IN_MHIGH_LSB = IN_MLOW_LSB + MASK_W;
    localparam int IN_BITS      = IN_MHIGH_LSB + MASK_W;
    localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest bit up
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_SLOT_LSB   = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_USED_LSB   = OUT_SLOT_LSB + SLOT_W;
    localparam int OUT_FREE_LSB   = OUT_USED_LSB + CNT_W;
    localparam int OUT_FULL_BIT   = OUT_FREE_LSB + CNT_W;
    localparam int OUT_BITS       = OUT_FULL_BIT + 1;
    localparam int OUT_DATA_W     = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PEEK       = 3'd0,
        CMD_ADD        = 3'd1,
        CMD_FIND       = 3'd2,
        CMD_DELETE     = 3'd3,
        CMD_DELETE_ALL = 3'd4
    } cmd_t;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DEL_UNUSED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD       = 2'd3;

endpackage

>>> src/rtsm_ram.sv
// ----------------------------------------------------------------------------
// rtsm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rtsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/route_table_slot_manager_unit.sv
// ----------------------------------------------------------------------------
// route_table_slot_manager_unit
// Routing table of slots with a stack of freed slot numbers and usage counters.
// ----------------------------------------------------------------------------
// One command is in flight at a time and each command returns exactly one
// result transfer. An input transfer is taken in the idle state and worked in
// the execute state; add, delete, delete all and unknown codes then go to the
// response state, and peek from a non-empty freed stack passes first through
// a peek state for one registered read of the stack memory. The response
// state loads the output register once it is free. Find walks the entry memory
// one slot per cycle through its single read port and stops early when a match
// is found. The result waits in its output register while the next command is
// already taken. Valid marks live in flops cleared at reset, so no clearing
// pass runs after reset. A write on the configuration channel sets table_length
// (clipped into 1..TABLE_DEPTH) and empties the table like delete all.
// ----------------------------------------------------------------------------
module route_table_slot_manager_unit
    import rtsm_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // cmd[2:0], slot[8:3], dest_id[32:9], port_mask_low[64:33],
    // port_mask_high[96:65], zero fill above
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // status[1:0], slot_out[7:2], used_slots[14:8], free_slots[21:15],
    // table_full[22], zero fill above
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    // table_length write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [TL_W-1:0]       cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int UW = CW + 1;
    localparam int LW = (CW > TL_W) ? CW : TL_W;
    localparam int EW = DEST_W + 2 * MASK_W;
    localparam logic [TL_W-1:0] TL_RESET = TL_W'((TABLE_DEPTH < 64) ? TABLE_DEPTH : 64);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PEEK,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [TL_W-1:0]         tl_reg, tl_next;
    logic [TABLE_DEPTH-1:0]  valid_reg, valid_next;
    logic [CW-1:0]           freed_reg, freed_next;
    logic [UW-1:0]           used_reg, used_next;
    logic [CNT_W-1:0]        free_reg, free_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [DEST_W-1:0]       dest_reg, dest_next;
    logic [MASK_W-1:0]       mlow_reg, mlow_next;
    logic [MASK_W-1:0]       mhigh_reg, mhigh_next;
    logic [CW-1:0]           scan_reg, scan_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]           cmp_idx_reg, cmp_idx_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [SLOT_W-1:0]       res_slot_reg, res_slot_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                    ent_wr_en, ent_rd_en;
    logic [AW-1:0]           ent_wr_addr, ent_rd_addr;
    logic [EW-1:0]           ent_wr_data, ent_rd_data;
    logic                    stk_wr_en, stk_rd_en;
    logic [AW-1:0]           stk_wr_addr, stk_rd_addr;
    logic [SLOT_W-1:0]       stk_wr_data, stk_rd_data;

    logic [AW-1:0]           slot_idx;
    logic                    slot_in_range;
    logic                    scan_more;
    logic                    cmp_hit;
    logic [TL_W-1:0]         tl_clip;
    logic [CNT_W-1:0]        used_out;

    // Entry store: {port_mask_high, port_mask_low, dest_id}
    rtsm_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    // Freed slot stack; entries at and above freed_reg are never read
    rtsm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // slot is below table_length whenever it is used to address, and
    // table_length never exceeds the depth
    assign slot_idx      = AW'(slot_reg);
    assign slot_in_range = ({1'b0, slot_reg} < tl_reg);
    assign scan_more     = (LW'(scan_reg) < LW'(tl_reg));
    assign cmp_hit       = cmp_vld_reg && valid_reg[cmp_idx_reg] &&
                           (ent_rd_data[DEST_W-1:0] == dest_reg);
    assign used_out      = CNT_W'(used_reg);

    // Clip the written length into 1..TABLE_DEPTH
    always_comb begin
        if (cfg_data == '0) begin
            tl_clip = TL_W'(1);
        end else if (LW'(cfg_data) > LW'(TABLE_DEPTH)) begin
            tl_clip = TL_W'(TABLE_DEPTH);
        end else begin
            tl_clip = cfg_data;
        end
    end

    always_comb begin
        state_next      = state_reg;
        tl_next         = tl_reg;
        valid_next      = valid_reg;
        freed_next      = freed_reg;
        used_next       = used_reg;
        free_next       = free_reg;
        cmd_next        = cmd_reg;
        slot_next       = slot_reg;
        dest_next       = dest_reg;
        mlow_next       = mlow_reg;
        mhigh_next      = mhigh_reg;
        scan_next       = scan_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        ent_wr_en   = 1'b0;
        ent_wr_addr = slot_idx;
        ent_wr_data = '0;
        ent_rd_en   = 1'b0;
        ent_rd_addr = AW'(scan_reg);
        stk_wr_en   = 1'b0;
        stk_wr_addr = AW'(freed_reg);
        stk_wr_data = slot_reg;
        stk_rd_en   = 1'b0;
        stk_rd_addr = AW'(freed_reg - CW'(1));

        // Drop the held result once the sink takes it
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = cmd_t'(s_tdata[IN_CMD_LSB +: CMD_W]);
                    slot_next  = s_tdata[IN_SLOT_LSB +: SLOT_W];
                    dest_next  = s_tdata[IN_DEST_LSB +: DEST_W];
                    mlow_next  = s_tdata[IN_MLOW_LSB +: MASK_W];
                    mhigh_next = s_tdata[IN_MHIGH_LSB +: MASK_W];
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                res_status_next = STATUS_OK;
                res_slot_next   = '0;
                state_next      = ST_RESP;
                unique case (cmd_reg)
                    CMD_PEEK: begin
                        if (freed_reg != '0) begin
                            // Top of the freed stack arrives next cycle
                            stk_rd_en  = 1'b1;
                            state_next = ST_PEEK;
                        end else if (free_reg != '0) begin
                            res_slot_next = SLOT_W'(used_reg);
                        end
                    end
                    CMD_ADD: begin
                        if (slot_in_range) begin
                            // Pop a freed slot or count a fresh one
                            if (freed_reg != '0) begin
                                freed_next = freed_reg - CW'(1);
                                if (free_reg != '0) begin
                                    free_next = free_reg - CNT_W'(1);
                                end
                                used_next = used_reg + UW'(1);
                            end else if (free_reg != '0) begin
                                free_next = free_reg - CNT_W'(1);
                                used_next = used_reg + UW'(1);
                            end
                            ent_wr_en            = 1'b1;
                            ent_wr_data          = {mhigh_reg, mlow_reg, dest_reg};
                            valid_next[slot_idx] = 1'b1;
                        end
                    end
                    CMD_FIND: begin
                        scan_next    = '0;
                        cmp_vld_next = 1'b0;
                        state_next   = ST_SCAN;
                    end
                    CMD_DELETE: begin
                        if (!slot_in_range || !valid_reg[slot_idx]) begin
                            res_status_next = STATUS_DEL_UNUSED;
                        end else begin
                            valid_next[slot_idx] = 1'b0;
                            ent_wr_en            = 1'b1;
                            // Push the slot unless the stack is full
                            if (freed_reg < CW'(TABLE_DEPTH)) begin
                                stk_wr_en  = 1'b1;
                                freed_next = freed_reg + CW'(1);
                            end
                            if (free_reg < tl_reg) begin
                                free_next = free_reg + CNT_W'(1);
                            end
                            if (used_reg != '0) begin
                                used_next = used_reg - UW'(1);
                            end
                        end
                    end
                    CMD_DELETE_ALL: begin
                        valid_next = '0;
                        freed_next = '0;
                        used_next  = '0;
                        free_next  = tl_reg;
                    end
                    default: begin
                    end
                endcase
            end

            ST_PEEK: begin
                res_slot_next = stk_rd_data;
                state_next    = ST_RESP;
            end

            ST_SCAN: begin
                // Issue one read per cycle and compare the slot read last cycle
                if (scan_more) begin
                    ent_rd_en    = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = AW'(scan_reg);
                    scan_next    = scan_reg + CW'(1);
                end else begin
                    cmp_vld_next = 1'b0;
                end
                if (cmp_hit) begin
                    res_status_next = STATUS_OK;
                    res_slot_next   = SLOT_W'(cmp_idx_reg);
                    state_next      = ST_RESP;
                end else if (!cmp_vld_reg && !scan_more) begin
                    res_status_next = STATUS_NO_MATCH;
                    res_slot_next   = '0;
                    state_next      = ST_RESP;
                end
            end

            ST_RESP: begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[OUT_STATUS_LSB +: STATUS_W] = res_status_reg;
                    m_tdata_next[OUT_SLOT_LSB +: SLOT_W]     = res_slot_reg;
                    m_tdata_next[OUT_USED_LSB +: CNT_W]      = used_out;
                    m_tdata_next[OUT_FREE_LSB +: CNT_W]      = free_reg;
                    m_tdata_next[OUT_FULL_BIT]               = (free_reg == '0);
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A length write empties the table under the new length
        if (cfg_valid) begin
            tl_next    = tl_clip;
            valid_next = '0;
            freed_next = '0;
            used_next  = '0;
            free_next  = tl_clip;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        slot_reg       <= slot_next;
        dest_reg       <= dest_next;
        mlow_reg       <= mlow_next;
        mhigh_reg      <= mhigh_next;
        scan_reg       <= scan_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_tdata_reg    <= m_tdata_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tl_reg       <= TL_RESET;
            valid_reg    <= '0;
            freed_reg    <= '0;
            used_reg     <= '0;
            free_reg     <= TL_RESET;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tl_reg       <= tl_next;
            valid_reg    <= valid_next;
            freed_reg    <= freed_next;
            used_reg     <= used_next;
            free_reg     <= free_next;
            cmp_vld_reg  <= cmp_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> src/rtsm_checker.sv
// ----------------------------------------------------------------------------
// rtsm_checker
// Port-level checks of the route table slot manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "route_table_slot_manager_unit_assert.svh"

module rtsm_checker
    import rtsm_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A stalled result stays offered
    `RTSM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // Full flag agrees with the free count it travels with
    `RTSM_ASSERT_NOW(a_full_flag, aclk, aresetn, m_tvalid, m_tdata[OUT_FULL_BIT] == (m_tdata[OUT_FREE_LSB +: CNT_W] == '0), "table_full disagrees with free_slots")

    // The result never carries the STATUS_BAD code
    `RTSM_ASSERT_NOW(a_status_code, aclk, aresetn, m_tvalid, m_tdata[OUT_STATUS_LSB +: STATUS_W] != STATUS_BAD, "undefined status code")

    // One command in flight: input closes right after a transfer
    `RTSM_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second command taken while busy")

endmodule

bind route_table_slot_manager_unit rtsm_checker u_rtsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/route_table_slot_manager_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_table_slot_manager_unit_test
// Self-checking bench for the route table slot manager: it drives commands on
// the input stream, predicts every result from its own copy of the table,
// freed-slot stack and counters, and checks each result transfer field by field.
// ----------------------------------------------------------------------------
module route_table_slot_manager_unit_test;
    import rtsm_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int STALL_LIMIT   = 2000;   // cycles without any transfer
    localparam int LONG_HOLD     = 300;    // receiver back-pressure stretch
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 80;     // longer than a full-length find
    localparam int DEPTH         = TABLE_DEPTH_DEF;
    localparam int DEST_POOL_N   = 8;
    localparam int PHASES        = 6;

    // Command codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESERVED_LAST  = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
        logic [DEST_W-1:0] dest;
        logic [MASK_W-1:0] mask_lo;
        logic [MASK_W-1:0] mask_hi;
    } route_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [CNT_W-1:0]    used_slots;
        logic [CNT_W-1:0]    free_slots;
        logic                table_full;
    } route_resp_t;

    // One line of the directed part: either a length write or a command,
    // the latter with a hand-written result where one is given
    typedef struct packed {
        logic             is_cfg;
        logic [TL_W-1:0]  cfg_value;
        route_cmd_t       cmd;
        logic             typed;
        route_resp_t      want;
    } directed_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // cmd, slot, dest_id, port_mask_low, port_mask_high, zero fill above
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // status, slot_out, used_slots, free_slots, table_full, zero fill above
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [TL_W-1:0]       cfg_data;

    route_table_slot_manager_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench copy of the table state
    // ------------------------------------------------------------------------
    logic              tbl_valid [DEPTH];
    logic [DEST_W-1:0] tbl_dest  [DEPTH];
    logic [SLOT_W-1:0] freed_stk [DEPTH];
    int                freed_depth;
    int                used_cnt;
    int                free_cnt;
    int                tbl_len;

    route_resp_t       pending_results [$];   // expected results, oldest first
    directed_row_t     directed_rows [$];
    logic [DEST_W-1:0] dest_pool [DEST_POOL_N];
    int                mismatches = 0;
    int                idle_cycles = 0;
    logic              quiet = 1'b0;          // no idling on either side
    logic              hold_off_req = 1'b0;   // ask the receiver for a long stall

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void empty_table();
        for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
        freed_depth = 0;
        used_cnt    = 0;
        free_cnt    = tbl_len;
    endfunction

    // Clip the written length into 1..DEPTH and empty the table
    function automatic void apply_table_length(input logic [TL_W-1:0] value);
        int n;
        n = value;
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
        tbl_len = n;
        empty_table();
    endfunction

    // Slot a peek hands out: freed stack top, else next unused slot, else 0
    function automatic logic [SLOT_W-1:0] next_free_slot();
        if (freed_depth > 0) return freed_stk[freed_depth - 1];
        if (free_cnt > 0) return SLOT_W'(used_cnt);
        return '0;
    endfunction

    // Apply one command to the bench table and return its result
    function automatic route_resp_t route_outcome(input route_cmd_t c);
        route_resp_t r;
        logic        hit;
        r   = '0;
        hit = 1'b0;
        case (c.cmd)
            CMD_PEEK: r.slot_out = next_free_slot();
            CMD_ADD: begin
                if (c.slot < tbl_len) begin
                    if (freed_depth > 0) begin
                        freed_depth--;
                        if (free_cnt > 0) free_cnt--;
                        used_cnt++;
                    end else if (free_cnt > 0) begin
                        free_cnt--;
                        used_cnt++;
                    end
                    tbl_dest[c.slot]  = c.dest;
                    tbl_valid[c.slot] = 1'b1;
                end
            end
            CMD_FIND: begin
                r.status = STATUS_NO_MATCH;
                for (int i = 0; i < tbl_len; i++) begin
                    if (!hit && tbl_valid[i] && tbl_dest[i] == c.dest) begin
                        hit        = 1'b1;
                        r.status   = STATUS_OK;
                        r.slot_out = SLOT_W'(i);
                    end
                end
            end
            CMD_DELETE: begin
                if (c.slot >= tbl_len || !tbl_valid[c.slot]) begin
                    r.status = STATUS_DEL_UNUSED;
                end else begin
                    tbl_valid[c.slot] = 1'b0;
                    tbl_dest[c.slot]  = '0;
                    if (freed_depth < DEPTH) begin
                        freed_stk[freed_depth] = c.slot;
                        freed_depth++;
                    end
                    if (free_cnt < tbl_len) free_cnt++;
                    if (used_cnt > 0) used_cnt--;
                end
            end
            CMD_DELETE_ALL: empty_table();
            default: ;
        endcase
        r.used_slots = CNT_W'(used_cnt);
        r.free_slots = CNT_W'(free_cnt);
        r.table_full = (free_cnt == 0);
        return r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_route_cmd(input route_cmd_t c);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[IN_CMD_LSB   +: CMD_W]  = c.cmd;
        d[IN_SLOT_LSB  +: SLOT_W] = c.slot;
        d[IN_DEST_LSB  +: DEST_W] = c.dest;
        d[IN_MLOW_LSB  +: MASK_W] = c.mask_lo;
        d[IN_MHIGH_LSB +: MASK_W] = c.mask_hi;
        return d;
    endfunction

    function automatic route_cmd_t make_cmd(input logic [CMD_W-1:0] op,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic [DEST_W-1:0] dest,
                                            input logic [MASK_W-1:0] lo,
                                            input logic [MASK_W-1:0] hi);
        route_cmd_t c;
        c.cmd     = op;
        c.slot    = slot;
        c.dest    = dest;
        c.mask_lo = lo;
        c.mask_hi = hi;
        return c;
    endfunction

    function automatic route_resp_t make_resp(input logic [STATUS_W-1:0] status,
                                              input int slot_out, input int used,
                                              input int free_n, input logic full);
        route_resp_t r;
        r.status     = status;
        r.slot_out   = SLOT_W'(slot_out);
        r.used_slots = CNT_W'(used);
        r.free_slots = CNT_W'(free_n);
        r.table_full = full;
        return r;
    endfunction

    function automatic void add_row(input logic is_cfg, input logic [TL_W-1:0] value,
                                    input route_cmd_t c, input logic typed,
                                    input route_resp_t want);
        directed_row_t row;
        row.is_cfg    = is_cfg;
        row.cfg_value = value;
        row.cmd       = c;
        row.typed     = typed;
        row.want      = want;
        directed_rows.push_back(row);
    endfunction

    // Mostly ids from a small pool so finds hit, sometimes a fresh one
    function automatic logic [DEST_W-1:0] pick_dest();
        if ($urandom_range(0, 3) == 0) return DEST_W'($urandom);
        return dest_pool[$urandom_range(0, DEST_POOL_N - 1)];
    endfunction

    // Random command shaped like route programming: peek then add at the
    // offered slot, finds of known ids, deletes of live entries, some noise.
    // With fill set, adds dominate so the table runs full.
    function automatic route_cmd_t random_route_cmd(input logic fill);
        route_cmd_t        c;
        int                pick;
        int                k;
        logic [SLOT_W-1:0] live [$];
        c.cmd     = CMD_PEEK;
        c.slot    = SLOT_W'($urandom_range(0, DEPTH - 1));
        c.dest    = pick_dest();
        c.mask_lo = $urandom;
        c.mask_hi = $urandom;
        pick      = $urandom_range(0, 99);
        if (pick < (fill ? 60 : 40)) begin
            c.cmd = CMD_ADD;
            k = $urandom_range(0, 9);
            if (k < 6 && next_free_slot() < tbl_len) c.slot = next_free_slot();
            else if (k < 9) c.slot = SLOT_W'($urandom_range(0, tbl_len - 1));
        end else if (pick < (fill ? 75 : 60)) begin
            c.cmd = CMD_FIND;
        end else if (pick < (fill ? 85 : 80)) begin
            c.cmd = CMD_DELETE;
            for (int i = 0; i < tbl_len; i++) if (tbl_valid[i]) live.push_back(SLOT_W'(i));
            if (live.size() > 0 && $urandom_range(0, 4) != 0)
                c.slot = live[$urandom_range(0, live.size() - 1)];
        end else if (pick < (fill ? 94 : 93)) begin
            c.cmd = CMD_PEEK;
        end else if (pick < (fill ? 94 : 95)) begin
            c.cmd = CMD_DELETE_ALL;
        end else begin
            c.cmd = CMD_W'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
        end
        return c;
    endfunction

    // Offer one command until it is taken, then queue its expected result
    task automatic issue_cmd(input route_cmd_t c, input logic typed, input route_resp_t want);
        route_resp_t predicted;
        s_tdata  <= pack_route_cmd(c);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = route_outcome(c);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Drop valid for a random burst now and then
    task automatic sender_gap(input int odds);
        if (!quiet && $urandom_range(1, odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // Stop offering, wait for every result, then let the block settle
    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_table_length(input logic [TL_W-1:0] value);
        drain_results(SETTLE_CYCLES);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_table_length(value);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [TL_W-1:0] len;
        int              n_items;

        // Hold every input at a known value and assert reset
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        apply_table_length(TL_W'(DEPTH));

        // Id pool: both extremes plus random ids
        dest_pool[0] = '0;
        dest_pool[1] = '1;
        for (int i = 2; i < DEST_POOL_N; i++) dest_pool[i] = DEST_W'($urandom);

        // Directed part. Rows with a typed result are states readable at a
        // glance; the rest go through the predictor.
        // Empty table right after reset: peek, missed find, delete of unused
        add_row(0, '0, make_cmd(CMD_PEEK, 6'd0, 24'h0, '0, '0),
                1, make_resp(STATUS_OK, 0, 0, 64, 0));
        add_row(0, '0, make_cmd(CMD_FIND, 6'd0, 24'h0, '0, '0),
                1, make_resp(STATUS_NO_MATCH, 0, 0, 64, 0));
        add_row(0, '0, make_cmd(CMD_DELETE, 6'd0, 24'h0, '0, '0),
                1, make_resp(STATUS_DEL_UNUSED, 0, 0, 64, 0));
        // Field extremes: lowest and highest slot, id and masks
        add_row(0, '0, make_cmd(CMD_ADD, 6'd0, 24'h0, 32'h0, 32'h0), 0, '0);
        add_row(0, '0, make_cmd(CMD_ADD, 6'd63, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                0, '0);
        add_row(0, '0, make_cmd(CMD_FIND, 6'd0, 24'hFF_FFFF, '0, '0), 0, '0);
        add_row(0, '0, make_cmd(CMD_FIND, 6'd63, 24'h0, '0, '0), 0, '0);
        // Add over a live slot, delete it, peek the freed slot, reuse the stack
        add_row(0, '0, make_cmd(CMD_ADD, 6'd63, 24'h5A_5A5A, 32'h1234_5678, 32'h9ABC_DEF0),
                0, '0);
        add_row(0, '0, make_cmd(CMD_DELETE, 6'd63, 24'h0, '0, '0), 0, '0);
        add_row(0, '0, make_cmd(CMD_PEEK, 6'd0, 24'h0, '0, '0), 0, '0);
        add_row(0, '0, make_cmd(CMD_ADD, 6'd10, 24'hA5_A5A5, 32'h5555_5555, 32'hAAAA_AAAA),
                0, '0);
        add_row(0, '0, make_cmd(CMD_DELETE, 6'd63, 24'h0, '0, '0), 0, '0);
        // Reserved codes leave everything as it is
        add_row(0, '0, make_cmd(CMD_RESERVED_FIRST, 6'd42, 24'h3C_3C3C, '0, '0), 0, '0);
        add_row(0, '0, make_cmd(CMD_RESERVED_FIRST + 3'd1, 6'd21, 24'hC3_C3C3, '1, '1),
                0, '0);
        add_row(0, '0, make_cmd(CMD_RESERVED_LAST, 6'd63, 24'hFF_FFFF, '0, '1), 0, '0);
        add_row(0, '0, make_cmd(CMD_DELETE_ALL, 6'd0, 24'h0, '0, '0),
                1, make_resp(STATUS_OK, 0, 0, 64, 0));
        add_row(0, '0, make_cmd(CMD_FIND, 6'd0, 24'h5A_5A5A, '0, '0),
                1, make_resp(STATUS_NO_MATCH, 0, 0, 64, 0));
        // Length 0 clips to one slot: add beyond the length, full table,
        // add over the only slot with no free slot left, delete beyond length
        add_row(1, 7'd0, '0, 0, '0);
        add_row(0, '0, make_cmd(CMD_PEEK, 6'd0, 24'h0, '0, '0),
                1, make_resp(STATUS_OK, 0, 0, 1, 0));
        add_row(0, '0, make_cmd(CMD_ADD, 6'd1, 24'h00_0001, '1, '0), 0, '0);
        add_row(0, '0, make_cmd(CMD_ADD, 6'd0, 24'h00_0001, '0, '1), 0, '0);
        add_row(0, '0, make_cmd(CMD_PEEK, 6'd0, 24'h0, '0, '0),
                1, make_resp(STATUS_OK, 0, 1, 0, 1));
        add_row(0, '0, make_cmd(CMD_ADD, 6'd0, 24'h00_0002, '1, '1), 0, '0);
        add_row(0, '0, make_cmd(CMD_DELETE, 6'd1, 24'h0, '0, '0), 0, '0);
        add_row(0, '0, make_cmd(CMD_FIND, 6'd0, 24'h00_0002, '0, '0), 0, '0);
        // Length 127 clips to the full depth
        add_row(1, 7'd127, '0, 0, '0);
        add_row(0, '0, make_cmd(CMD_PEEK, 6'd0, 24'h0, '0, '0),
                1, make_resp(STATUS_OK, 0, 0, 64, 0));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_table_length(directed_rows[i].cfg_value);
            end else begin
                sender_gap(4);
                issue_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases, each under its own table length. The first fills a
        // full-depth table; the last runs with no idling at all.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin len = 7'd64;  n_items = 160; end
                1:       begin len = 7'd2;   n_items = 70;  end
                2:       begin len = TL_W'($urandom_range(3, 63)); n_items = 75; end
                3:       begin len = 7'd1;   n_items = 70;  end
                4:       begin len = 7'd127; n_items = 80;  end
                default: begin len = 7'd5;   n_items = 70;  end
            endcase
            write_table_length(len);
            quiet = (p == PHASES - 1);
            for (int k = 0; k < n_items; k++) begin
                // Back-pressure hard once while the sender keeps offering
                if (p == 0 && k == 40) hold_off_req = 1'b1;
                sender_gap((p % 2 == 1) ? 3 : 8);
                issue_cmd(random_route_cmd(p == 0), 1'b0, '0);
            end
        end

        drain_results(TAIL_CYCLES);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result receiver: random ready bursts, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        logic hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off_req && !hold_done) begin
                // Hold ready low long enough for the block to fill and stall
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: compare each result transfer with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        route_resp_t got;
        route_resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status     = m_tdata[OUT_STATUS_LSB +: STATUS_W];
            got.slot_out   = m_tdata[OUT_SLOT_LSB +: SLOT_W];
            got.used_slots = m_tdata[OUT_USED_LSB +: CNT_W];
            got.free_slots = m_tdata[OUT_FREE_LSB +: CNT_W];
            got.table_full = m_tdata[OUT_FULL_BIT];
            if (pending_results.size() == 0) begin
                flag_mismatch("result with no command pending", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    flag_mismatch("status", got.status, want.status);
                if (got.slot_out !== want.slot_out)
                    flag_mismatch("slot_out", got.slot_out, want.slot_out);
                if (got.used_slots !== want.used_slots)
                    flag_mismatch("used_slots", got.used_slots, want.used_slots);
                if (got.free_slots !== want.free_slots)
                    flag_mismatch("free_slots", got.free_slots, want.free_slots);
                if (got.table_full !== want.table_full)
                    flag_mismatch("table_full", got.table_full, want.table_full);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no transfer happens for too long
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule
